// ----- hdl/nnt_pkg.sv -----
`timescale 1ns / 1ps
package nnt_pkg;

   localparam int CNT_W   = 7;   // city and start counts, 1..64
   localparam int CITY_W  = 6;   // city index field on the ports
   localparam int LABEL_W = 8;
   localparam int COST_W  = 22;
   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_LABEL  = 2'd1;
   localparam logic [1:0] OP_RUN    = 2'd2;

   localparam logic CSR_CITY_COUNT  = 1'b0;
   localparam logic CSR_START_COUNT = 1'b1;

   typedef struct packed {
      logic [CNT_W-1:0] cities;   // effective city count
      logic [CNT_W-1:0] starts;   // effective start count
   } run_cfg_type;

   typedef struct packed {
      logic [CITY_W-1:0]  position;
      logic [CITY_W-1:0]  city_index;
      logic [LABEL_W-1:0] city_label;
      logic [COST_W-1:0]  tour_cost;
      logic               last;
   } beat_type;

endpackage

// ----- hdl/nnt_ram.sv -----
`timescale 1ns / 1ps
module nnt_ram #(
   parameter int W  = 8,
   parameter int AW = 6
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [W-1:0]  wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [W-1:0]  rdata
);

   logic [W-1:0] mem [2**AW];
   logic [W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/nnt_engine.sv -----
`timescale 1ns / 1ps
module nnt_engine #(
   parameter int IW = 6,
   parameter int WB = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nnt_pkg::run_cfg_type  cfg,
   input  logic                  run,
   output logic                  idle,
   output logic                  w_re,
   output logic [2*IW-1:0]       w_raddr,
   input  logic [WB-1:0]         w_rdata,
   output logic                  t_we,
   output logic [IW:0]           t_waddr,
   output logic [IW-1:0]         t_wdata,
   output logic                  t_re,
   output logic [IW:0]           t_raddr,
   input  logic [IW-1:0]         t_rdata,
   output logic                  l_re,
   output logic [IW-1:0]         l_raddr,
   input  logic [nnt_pkg::LABEL_W-1:0] l_rdata,
   output logic                  out_valid,
   input  logic                  out_ready,
   output nnt_pkg::beat_type     out_beat
);

   localparam int SW = ((WB > nnt_pkg::COST_W) ? WB : nnt_pkg::COST_W) + 1;
   localparam int NV = 2**IW;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_START   = 4'd1;
   localparam logic [3:0] S_SCAN    = 4'd2;
   localparam logic [3:0] S_STEP    = 4'd3;
   localparam logic [3:0] S_CLOSE   = 4'd4;
   localparam logic [3:0] S_CLOSE_D = 4'd5;
   localparam logic [3:0] S_JUDGE   = 4'd6;
   localparam logic [3:0] S_E_TOUR  = 4'd7;
   localparam logic [3:0] S_E_LABEL = 4'd8;
   localparam logic [3:0] S_E_SHOW  = 4'd9;
   localparam logic [3:0] S_E_WAIT  = 4'd10;

   logic [3:0]                   state_ff, state_in;
   logic [nnt_pkg::CNT_W-1:0]    st_ff, st_in;
   logic [nnt_pkg::CNT_W-1:0]    k_ff, k_in;
   logic [nnt_pkg::CNT_W-1:0]    c_ff, c_in;
   logic [IW-1:0]                here_ff, here_in;
   logic                         dv_ff, dv_in;
   logic [IW-1:0]                cd_ff, cd_in;
   logic                         found_ff, found_in;
   logic [WB-1:0]                least_ff, least_in;
   logic [IW-1:0]                pick_ff, pick_in;
   logic [nnt_pkg::COST_W-1:0]   cost_ff, cost_in;
   logic [nnt_pkg::COST_W-1:0]   best_ff, best_in;
   logic                         have_ff, have_in;
   logic                         bank_ff, bank_in;
   logic [NV-1:0]                visited_ff, visited_in;
   logic                         ov_ff, ov_in;
   nnt_pkg::beat_type            beat_ff, beat_in;
   logic [WB-1:0]                add_w;
   logic [SW-1:0]                sum;
   logic [nnt_pkg::COST_W-1:0]   sat;

   assign add_w = (state_ff == S_CLOSE_D) ? w_rdata : least_ff;
   assign sum   = SW'(cost_ff) + SW'(add_w);
   assign sat   = (sum > SW'(nnt_pkg::COST_MAX)) ? nnt_pkg::COST_MAX
                                                  : sum[nnt_pkg::COST_W-1:0];

   always_comb begin
      state_in   = state_ff;
      st_in      = st_ff;
      k_in       = k_ff;
      c_in       = c_ff;
      here_in    = here_ff;
      dv_in      = 1'b0;
      cd_in      = cd_ff;
      found_in   = found_ff;
      least_in   = least_ff;
      pick_in    = pick_ff;
      cost_in    = cost_ff;
      best_in    = best_ff;
      have_in    = have_ff;
      bank_in    = bank_ff;
      visited_in = visited_ff;
      ov_in      = ov_ff;
      beat_in    = beat_ff;
      w_re       = 1'b0;
      w_raddr    = {here_ff, c_ff[IW-1:0]};
      t_we       = 1'b0;
      t_waddr    = {~bank_ff, k_ff[IW-1:0]};
      t_wdata    = pick_ff;
      t_re       = 1'b0;
      t_raddr    = {bank_ff, k_ff[IW-1:0]};
      l_re       = 1'b0;
      l_raddr    = t_rdata;
      case (state_ff)
         S_IDLE: begin
            if (run) begin
               st_in    = '0;
               have_in  = 1'b0;
               best_in  = nnt_pkg::COST_MAX;
               state_in = S_START;
            end
         end
         S_START: begin
            visited_in = '0;
            visited_in[st_ff[IW-1:0]] = 1'b1;
            t_we     = 1'b1;
            t_waddr  = {~bank_ff, {IW{1'b0}}};
            t_wdata  = st_ff[IW-1:0];
            here_in  = st_ff[IW-1:0];
            cost_in  = '0;
            k_in     = nnt_pkg::CNT_W'(1);
            c_in     = '0;
            found_in = 1'b0;
            state_in = (cfg.cities == nnt_pkg::CNT_W'(1)) ? S_CLOSE : S_SCAN;
         end
         S_SCAN: begin
            // issue one weight read a cycle, judge the beat read last cycle
            if (c_ff < cfg.cities) begin
               w_re  = 1'b1;
               dv_in = 1'b1;
               cd_in = c_ff[IW-1:0];
               c_in  = c_ff + 1'b1;
            end
            if (dv_ff && !visited_ff[cd_ff] && (!found_ff || w_rdata < least_ff)) begin
               found_in = 1'b1;
               least_in = w_rdata;
               pick_in  = cd_ff;
            end
            if (c_ff == cfg.cities && !dv_ff) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cost_in  = sat;
            here_in  = pick_ff;
            visited_in[pick_ff] = 1'b1;
            t_we     = 1'b1;
            k_in     = k_ff + 1'b1;
            c_in     = '0;
            found_in = 1'b0;
            state_in = (k_ff + 1'b1 == cfg.cities) ? S_CLOSE : S_SCAN;
         end
         S_CLOSE: begin
            w_re     = 1'b1;
            w_raddr  = {here_ff, st_ff[IW-1:0]};
            state_in = S_CLOSE_D;
         end
         S_CLOSE_D: begin
            cost_in  = sat;
            state_in = S_JUDGE;
         end
         S_JUDGE: begin
            if (!have_ff || cost_ff < best_ff) begin
               have_in = 1'b1;
               best_in = cost_ff;
               bank_in = ~bank_ff;
            end
            st_in = st_ff + 1'b1;
            if (st_ff + 1'b1 == cfg.starts) begin
               k_in     = '0;
               state_in = S_E_TOUR;
            end else begin
               state_in = S_START;
            end
         end
         S_E_TOUR: begin
            t_re     = 1'b1;
            state_in = S_E_LABEL;
         end
         S_E_LABEL: begin
            l_re     = 1'b1;
            state_in = S_E_SHOW;
         end
         S_E_SHOW: begin
            beat_in.position   = nnt_pkg::CITY_W'(k_ff);
            beat_in.city_index = nnt_pkg::CITY_W'(t_rdata);
            beat_in.city_label = l_rdata;
            beat_in.tour_cost  = best_ff;
            beat_in.last       = (k_ff + 1'b1 == cfg.cities);
            ov_in    = 1'b1;
            state_in = S_E_WAIT;
         end
         S_E_WAIT: begin
            if (ov_ff && out_ready) begin
               ov_in = 1'b0;
               if (beat_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_E_TOUR;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         dv_ff      <= 1'b0;
         ov_ff      <= 1'b0;
         visited_ff <= '0;
         cost_ff    <= '0;
         best_ff    <= nnt_pkg::COST_MAX;
         have_ff    <= 1'b0;
         bank_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dv_ff      <= dv_in;
         ov_ff      <= ov_in;
         visited_ff <= visited_in;
         cost_ff    <= cost_in;
         best_ff    <= best_in;
         have_ff    <= have_in;
         bank_ff    <= bank_in;
      end
      st_ff    <= st_in;
      k_ff     <= k_in;
      c_ff     <= c_in;
      here_ff  <= here_in;
      cd_ff    <= cd_in;
      found_ff <= found_in;
      least_ff <= least_in;
      pick_ff  <= pick_in;
      beat_ff  <= beat_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign out_valid = ov_ff;
   assign out_beat  = beat_ff;

   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> (state_ff == S_E_WAIT))
      else $error("result beat shown outside the wait state");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(idle && ov_ff))
      else $error("input taken while a result beat is pending");

   a_pick_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> found_ff)
      else $error("step with no unvisited city found");

   a_close_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLOSE_D) |-> ($past(state_ff) == S_CLOSE))
      else $error("closing edge added without its read");

endmodule

// ----- hdl/nearest_neighbor_tour_builder.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tuser=op, tdata=row,col,value
// rsp      out  rsp_tvalid/tready    tdata=position,city_index,city_label,tour_cost; tlast=last
// csr      in   csr_we               csr_index, csr_wdata
// A run searches from each start in turn, bound by the single weight read port
// (one matrix entry a cycle), then streams one result beat at a time, each held until taken.
// Reset clears control state and sets city_count 4, start_count 1; memories
// are not cleared. req_tready is low from a run until its last beat is taken.
module nearest_neighbor_tour_builder #(
   parameter int MAX_CITIES  = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // row[5:0], col[11:6], value[27:12]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // position[5:0], city_index[11:6], city_label[19:12],
                                    // tour_cost[41:20]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int NC = (MAX_CITIES < 64) ? MAX_CITIES : 64;
   localparam int IW = $clog2(NC);

   logic [nnt_pkg::CNT_W-1:0] city_count_ff, start_count_ff;
   logic [nnt_pkg::CNT_W-1:0] n_eff, s_eff;
   nnt_pkg::run_cfg_type      cfg;
   nnt_pkg::beat_type         beat;
   logic                      accept, idle;
   logic [5:0]                row, col;
   logic [15:0]               value;
   logic [31:0]               value32;
   logic                      w_we, l_we;
   logic                      w_re, t_we, t_re, l_re;
   logic [2*IW-1:0]           w_raddr;
   logic [WEIGHT_BITS-1:0]    w_rdata;
   logic [IW:0]               t_waddr, t_raddr;
   logic [IW-1:0]             t_wdata, t_rdata, l_raddr;
   logic [nnt_pkg::LABEL_W-1:0] l_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff  <= nnt_pkg::CNT_W'(4);
         start_count_ff <= nnt_pkg::CNT_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            nnt_pkg::CSR_CITY_COUNT:  city_count_ff  <= csr_wdata;
            nnt_pkg::CSR_START_COUNT: start_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign n_eff = (city_count_ff == '0) ? nnt_pkg::CNT_W'(1) :
                  (city_count_ff > nnt_pkg::CNT_W'(NC)) ? nnt_pkg::CNT_W'(NC) : city_count_ff;
   assign s_eff = (start_count_ff == '0) ? nnt_pkg::CNT_W'(1) :
                  (start_count_ff > n_eff) ? n_eff : start_count_ff;
   assign cfg.cities = n_eff;
   assign cfg.starts = s_eff;

   assign req_tready = idle;
   assign accept     = req_tvalid && req_tready;
   assign row        = req_tdata[5:0];
   assign col        = req_tdata[11:6];
   assign value      = req_tdata[27:12];
   assign value32    = {16'b0, value};

   // drop writes outside the matrix
   assign w_we = accept && (req_tuser == nnt_pkg::OP_WEIGHT) &&
                 (7'(row) < 7'(NC)) && (7'(col) < 7'(NC));
   assign l_we = accept && (req_tuser == nnt_pkg::OP_LABEL) && (7'(row) < 7'(NC));

   nnt_ram #(.W(WEIGHT_BITS), .AW(2*IW)) u_weight (
      .clock (clock),
      .we    (w_we),
      .waddr ({row[IW-1:0], col[IW-1:0]}),
      .wdata (value32[WEIGHT_BITS-1:0]),
      .re    (w_re),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   nnt_ram #(.W(nnt_pkg::LABEL_W), .AW(IW)) u_label (
      .clock (clock),
      .we    (l_we),
      .waddr (row[IW-1:0]),
      .wdata (value[nnt_pkg::LABEL_W-1:0]),
      .re    (l_re),
      .raddr (l_raddr),
      .rdata (l_rdata)
   );

   // two tour banks: one holds the best tour, the other the tour being built
   nnt_ram #(.W(IW), .AW(IW+1)) u_tour (
      .clock (clock),
      .we    (t_we),
      .waddr (t_waddr),
      .wdata (t_wdata),
      .re    (t_re),
      .raddr (t_raddr),
      .rdata (t_rdata)
   );

   nnt_engine #(.IW(IW), .WB(WEIGHT_BITS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .run       (accept && (req_tuser == nnt_pkg::OP_RUN)),
      .idle      (idle),
      .w_re      (w_re),
      .w_raddr   (w_raddr),
      .w_rdata   (w_rdata),
      .t_we      (t_we),
      .t_waddr   (t_waddr),
      .t_wdata   (t_wdata),
      .t_re      (t_re),
      .t_raddr   (t_raddr),
      .t_rdata   (t_rdata),
      .l_re      (l_re),
      .l_raddr   (l_raddr),
      .l_rdata   (l_rdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (beat)
   );

   assign rsp_tdata = {6'b0, beat.tour_cost, beat.city_label, beat.city_index, beat.position};
   assign rsp_tlast = beat.last;

endmodule
